[design/ccr_pkg.sv]
// ----------------------------------------------------------------------------
// ccr_pkg
// Types, codes and constants shared by the channel chunk reassembler.
// ----------------------------------------------------------------------------
`default_nettype none

package ccr_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int MAX_MSG_DEF  = 1024 * 4;
    localparam int HDR_BYTES    = 8;
    localparam int SIZE_W       = 13;
    localparam int BYTE_W       = 8;

    localparam logic [SIZE_W-1:0] LIMIT_RESET = SIZE_W'(4096);

    typedef enum logic [1:0] {
        KIND_VERDICT = 2'd0,
        KIND_BYTE    = 2'd1,
        KIND_NONE    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        V_OK         = 3'd0,
        V_BAD_CHAN   = 3'd1,
        V_SHORT_HDR  = 3'd2,
        V_OVER_LIMIT = 3'd3,
        V_NO_PAYLOAD = 3'd4,
        V_TOO_LONG   = 3'd5
    } verdict_t;

    typedef enum logic [3:0] {
        PH_CHAN = 4'b0001,
        PH_HDR  = 4'b0010,
        PH_PAY  = 4'b0100,
        PH_SKIP = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [SIZE_W-1:0] len;
        logic [SIZE_W-1:0] rem;
    } tbl_word_t;

    typedef struct packed {
        logic              hdr_ok;
        logic              msg_done;
        logic [BYTE_W-1:0] chan;
    } chunk_evt_t;

    typedef struct packed {
        logic              valid;
        verdict_t          verdict;
        logic [BYTE_W-1:0] chan;
        logic              done;
    } verdict_res_t;

endpackage

`default_nettype wire

[design/channel_chunk_reassembler.sv]
// ----------------------------------------------------------------------------
// channel_chunk_reassembler
// Rebuilds per-channel messages from chunk bytes and streams them out on fetch.
// ----------------------------------------------------------------------------
// Takes one word per clock, in any mix of chunk bytes and fetch requests,
// while the output keeps up. Each word yields at most one result, held in
// a first stage register beside the message store read and then in the
// output register. Message bytes sit in a single store RAM of CHANNELS *
// MAX_MSG entries, written by the payload path and read by the fetch path;
// a small channel table RAM holds each channel's length and remaining
// count. Neither RAM needs a clear after reset. The input side stalls only
// while a result is held in the output register and the sink is not ready.
// ----------------------------------------------------------------------------
`default_nettype none

module channel_chunk_reassembler
    import ccr_pkg::*;
#(
    parameter  int CHANNELS = CHANNELS_DEF,
    parameter  int MAX_MSG  = MAX_MSG_DEF,
    localparam int ADDR_W   = $clog2(CHANNELS * MAX_MSG)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] in_byte
    input  wire logic [0:0]        s_tuser,   // [0] req_type
    input  wire logic              s_tlast,   // chunk_last

    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [23:0]            m_tdata,   // [2:0] verdict, [10:3] chan,
                                              // [18:11] msg_byte, [19] message_done
    output logic [1:0]             m_tuser,   // [1:0] resp_kind
    output logic                   m_tlast,   // msg_last

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [SIZE_W-1:0] cfg_data   // size_limit
);

    logic [SIZE_W-1:0] size_limit_reg;

    logic              accept, chunk_valid, fetch_valid;
    chunk_evt_t        evt;
    verdict_res_t      vres;

    logic              st_we, st_re;
    logic [ADDR_W-1:0] st_waddr, st_raddr;
    logic [BYTE_W:0]   st_wdata, st_rdata;

    logic              hit;
    logic [BYTE_W-1:0] hit_chan;

    logic              s1_valid_reg, s1_valid_next;
    kind_t             s1_kind_reg, s1_kind_next;
    verdict_t          s1_verdict_reg, s1_verdict_next;
    logic [BYTE_W-1:0] s1_chan_reg, s1_chan_next;
    logic              s1_done_reg, s1_done_next;
    logic              s1_adv;

    logic              m_valid_reg, m_valid_next;
    kind_t             m_kind_reg, m_kind_next;
    logic [23:0]       m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;

    logic              s1_is_byte;
    logic [BYTE_W-1:0] s1_byte;

    assign cfg_ready   = 1'b1;
    assign s1_adv      = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready    = !s1_valid_reg || s1_adv;
    assign accept      = s_tvalid && s_tready;
    assign chunk_valid = accept && !s_tuser[0];
    assign fetch_valid = accept && s_tuser[0];

    ccr_chunk #(
        .CHANNELS (CHANNELS),
        .MAX_MSG  (MAX_MSG)
    ) u_chunk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (chunk_valid),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .size_limit (size_limit_reg),
        .evt        (evt),
        .vres       (vres),
        .st_we      (st_we),
        .st_waddr   (st_waddr),
        .st_wdata   (st_wdata)
    );

    ccr_fetch #(
        .CHANNELS (CHANNELS),
        .MAX_MSG  (MAX_MSG)
    ) u_fetch (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fetch_valid (fetch_valid),
        .evt         (evt),
        .rd_last     (st_rdata[BYTE_W]),
        .st_re       (st_re),
        .st_raddr    (st_raddr),
        .hit         (hit),
        .hit_chan    (hit_chan)
    );

    ccr_ram #(
        .WIDTH (BYTE_W + 1),
        .DEPTH (CHANNELS * MAX_MSG)
    ) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign s1_is_byte = s1_kind_reg == KIND_BYTE;
    assign s1_byte    = s1_is_byte ? st_rdata[BYTE_W-1:0] : '0;

    always_comb begin
        s1_valid_next   = s1_valid_reg && !s1_adv;
        s1_kind_next    = s1_kind_reg;
        s1_verdict_next = s1_verdict_reg;
        s1_chan_next    = s1_chan_reg;
        s1_done_next    = s1_done_reg;
        if (fetch_valid) begin
            s1_valid_next   = 1'b1;
            s1_kind_next    = hit ? KIND_BYTE : KIND_NONE;
            s1_verdict_next = V_OK;
            s1_chan_next    = hit ? hit_chan : '0;
            s1_done_next    = 1'b0;
        end else if (vres.valid) begin
            s1_valid_next   = 1'b1;
            s1_kind_next    = KIND_VERDICT;
            s1_verdict_next = vres.verdict;
            s1_chan_next    = vres.chan;
            s1_done_next    = vres.done;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
            m_kind_next  = s1_kind_reg;
            m_data_next  = {4'b0, s1_done_reg, s1_byte, s1_chan_reg, s1_verdict_reg};
            m_last_next  = s1_is_byte && st_rdata[BYTE_W];
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_limit_reg <= LIMIT_RESET;
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                size_limit_reg <= cfg_data;
            end
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_kind_reg    <= s1_kind_next;
        s1_verdict_reg <= s1_verdict_next;
        s1_chan_reg    <= s1_chan_next;
        s1_done_reg    <= s1_done_next;
        m_kind_reg     <= m_kind_next;
        m_data_reg     <= m_data_next;
        m_last_reg     <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

[design/ccr_ram.sv]
// ----------------------------------------------------------------------------
// ccr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ccr_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/ccr_chunk.sv]
// ----------------------------------------------------------------------------
// ccr_chunk
// Chunk parser: channel byte, size header, payload writes and verdicts.
// Per-channel length and remaining count live in a small channel table RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module ccr_chunk
    import ccr_pkg::*;
#(
    parameter  int CHANNELS = CHANNELS_DEF,
    parameter  int MAX_MSG  = MAX_MSG_DEF,
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int ADDR_W   = $clog2(CHANNELS * MAX_MSG)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              item_valid,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              in_last,
    input  wire logic [SIZE_W-1:0] size_limit,
    output chunk_evt_t             evt,
    output verdict_res_t           vres,
    output logic                   st_we,
    output logic [ADDR_W-1:0]      st_waddr,
    output logic [BYTE_W:0]        st_wdata
);

    localparam int TBL_W = $bits(tbl_word_t);

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   cur_chan_reg, cur_chan_next;
    logic [SIZE_W-1:0]   cnt_reg, cnt_next;
    verdict_t            err_reg, err_next;
    logic [SIZE_W-1:0]   hdr_size_reg, hdr_size_next;
    logic                hdr_over_reg, hdr_over_next;
    logic [CHANNELS-1:0] busy_reg, busy_next;
    tbl_word_t           wk_reg, wk_next;
    logic                load_pend_reg, load_pend_next;

    logic                tbl_we, tbl_re;
    logic [CH_W-1:0]     tbl_waddr, tbl_raddr;
    logic [TBL_W-1:0]    tbl_wdata, tbl_rdata;

    logic [CH_W-1:0]     chan_idx, byte_idx;
    logic                byte_ok;
    tbl_word_t           cur;
    logic [SIZE_W-1:0]   pay_off, new_rem;
    verdict_t            vcode;
    logic                done_now;

    ccr_ram #(
        .WIDTH (TBL_W),
        .DEPTH (CHANNELS)
    ) u_tbl (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    assign chan_idx  = cur_chan_reg[CH_W-1:0];
    assign byte_idx  = in_byte[CH_W-1:0];
    assign byte_ok   = {1'b0, in_byte} < (BYTE_W + 1)'(CHANNELS);
    assign cur       = load_pend_reg ? tbl_word_t'(tbl_rdata) : wk_reg;
    assign pay_off   = cur.len - cur.rem + cnt_reg;
    assign new_rem   = cur.rem - (cnt_reg + SIZE_W'(1));
    assign tbl_raddr = byte_idx;
    assign tbl_waddr = chan_idx;
    assign st_waddr  = ADDR_W'(chan_idx) * ADDR_W'(MAX_MSG) + ADDR_W'(pay_off);
    assign st_wdata  = {(pay_off + SIZE_W'(1)) == cur.len, in_byte};

    always_comb begin
        phase_next     = phase_reg;
        cur_chan_next  = cur_chan_reg;
        cnt_next       = cnt_reg;
        err_next       = err_reg;
        hdr_size_next  = hdr_size_reg;
        hdr_over_next  = hdr_over_reg;
        busy_next      = busy_reg;
        wk_next        = cur;
        load_pend_next = 1'b0;
        tbl_we         = 1'b0;
        tbl_re         = 1'b0;
        tbl_wdata      = cur;
        st_we          = 1'b0;
        evt            = '0;
        evt.chan       = cur_chan_reg;
        vres           = '0;
        vcode          = V_OK;
        done_now       = 1'b0;

        if (item_valid) begin
            unique case (phase_reg)
                PH_CHAN: begin
                    cur_chan_next = in_byte;
                    cnt_next      = '0;
                    hdr_size_next = '0;
                    hdr_over_next = 1'b0;
                    if (!byte_ok) begin
                        err_next   = V_BAD_CHAN;
                        phase_next = PH_SKIP;
                        vcode      = V_BAD_CHAN;
                    end else if (!busy_reg[byte_idx]) begin
                        phase_next = PH_HDR;
                        vcode      = V_SHORT_HDR;
                    end else begin
                        phase_next     = PH_PAY;
                        tbl_re         = 1'b1;
                        load_pend_next = 1'b1;
                        vcode          = V_NO_PAYLOAD;
                    end
                end
                PH_HDR: begin
                    cnt_next = cnt_reg + SIZE_W'(1);
                    vcode    = V_SHORT_HDR;
                    if (cnt_reg == '0) begin
                        hdr_size_next[7:0] = in_byte;
                    end else if (cnt_reg == SIZE_W'(1)) begin
                        hdr_size_next[SIZE_W-1:8] = in_byte[SIZE_W-9:0];
                        hdr_over_next = hdr_over_reg | (|in_byte[BYTE_W-1:SIZE_W-8]);
                    end else begin
                        hdr_over_next = hdr_over_reg | (|in_byte);
                    end
                    if (cnt_reg == SIZE_W'(HDR_BYTES - 1)) begin
                        if (hdr_over_next || hdr_size_next > size_limit ||
                            32'(hdr_size_next) > 32'(MAX_MSG)) begin
                            err_next   = V_OVER_LIMIT;
                            phase_next = PH_SKIP;
                            vcode      = V_OVER_LIMIT;
                        end else begin
                            tbl_we              = 1'b1;
                            tbl_wdata           = {hdr_size_next, hdr_size_next};
                            wk_next.len         = hdr_size_next;
                            wk_next.rem         = hdr_size_next;
                            busy_next[chan_idx] = hdr_size_next != '0;
                            evt.hdr_ok          = 1'b1;
                            cnt_next            = '0;
                            phase_next          = PH_PAY;
                            vcode               = V_NO_PAYLOAD;
                        end
                    end
                end
                PH_PAY: begin
                    if (cnt_reg >= cur.rem) begin
                        err_next   = V_TOO_LONG;
                        phase_next = PH_SKIP;
                        vcode      = V_TOO_LONG;
                    end else begin
                        st_we    = 1'b1;
                        cnt_next = cnt_reg + SIZE_W'(1);
                        if (in_last) begin
                            tbl_we              = 1'b1;
                            tbl_wdata           = {cur.len, new_rem};
                            busy_next[chan_idx] = new_rem != '0;
                            done_now            = new_rem == '0;
                            evt.msg_done        = done_now;
                        end
                    end
                end
                PH_SKIP: begin
                    vcode = err_reg;
                end
                default: begin
                    phase_next = PH_CHAN;
                end
            endcase

            if (in_last) begin
                vres.valid    = 1'b1;
                vres.verdict  = vcode;
                vres.chan     = cur_chan_next;
                vres.done     = done_now;
                phase_next    = PH_CHAN;
                cnt_next      = '0;
                err_next      = V_OK;
                hdr_size_next = '0;
                hdr_over_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_CHAN;
            cur_chan_reg  <= '0;
            cnt_reg       <= '0;
            err_reg       <= V_OK;
            hdr_size_reg  <= '0;
            hdr_over_reg  <= 1'b0;
            busy_reg      <= '0;
            load_pend_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            cur_chan_reg  <= cur_chan_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            hdr_size_reg  <= hdr_size_next;
            hdr_over_reg  <= hdr_over_next;
            busy_reg      <= busy_next;
            load_pend_reg <= load_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        wk_reg <= wk_next;
    end

endmodule

`default_nettype wire

[design/ccr_fetch.sv]
// ----------------------------------------------------------------------------
// ccr_fetch
// Fetch control: complete-message flags, read pointer and store read address.
// The last-byte flag comes back with the store data and is applied in the
// cycle after the read.
// ----------------------------------------------------------------------------
`default_nettype none

module ccr_fetch
    import ccr_pkg::*;
#(
    parameter  int CHANNELS = CHANNELS_DEF,
    parameter  int MAX_MSG  = MAX_MSG_DEF,
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int ADDR_W   = $clog2(CHANNELS * MAX_MSG)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              fetch_valid,
    input  wire chunk_evt_t        evt,
    input  wire logic              rd_last,
    output logic                   st_re,
    output logic [ADDR_W-1:0]      st_raddr,
    output logic                   hit,
    output logic [BYTE_W-1:0]      hit_chan
);

    logic [CHANNELS-1:0] complete_reg, complete_next;
    logic [SIZE_W-1:0]   rp_reg, rp_next;
    logic                pend_reg, pend_next;
    logic [CH_W-1:0]     pend_chan_reg, pend_chan_next;

    logic [CHANNELS-1:0] eff_complete;
    logic [SIZE_W-1:0]   eff_rp;
    logic [CH_W-1:0]     idx;
    logic [CH_W-1:0]     evt_idx;
    logic                freed;

    assign freed    = pend_reg && rd_last;
    assign eff_rp   = freed ? '0 : rp_reg;
    assign evt_idx  = evt.chan[CH_W-1:0];
    assign hit_chan = BYTE_W'(idx);
    assign st_raddr = ADDR_W'(idx) * ADDR_W'(MAX_MSG) + ADDR_W'(eff_rp);

    always_comb begin
        eff_complete = complete_reg;
        if (freed) begin
            eff_complete[pend_chan_reg] = 1'b0;
        end
        hit = 1'b0;
        idx = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (eff_complete[i]) begin
                hit = 1'b1;
                idx = CH_W'(i);
            end
        end
    end

    always_comb begin
        complete_next  = eff_complete;
        rp_next        = eff_rp;
        pend_next      = 1'b0;
        pend_chan_next = pend_chan_reg;
        st_re          = 1'b0;
        if (fetch_valid && hit) begin
            st_re          = 1'b1;
            rp_next        = eff_rp + SIZE_W'(1);
            pend_next      = 1'b1;
            pend_chan_next = idx;
        end
        if (evt.hdr_ok) begin
            complete_next[evt_idx] = 1'b0;
            rp_next                = '0;
        end
        if (evt.msg_done) begin
            complete_next[evt_idx] = 1'b1;
            rp_next                = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            complete_reg  <= '0;
            rp_reg        <= '0;
            pend_reg      <= 1'b0;
            pend_chan_reg <= '0;
        end else begin
            complete_reg  <= complete_next;
            rp_reg        <= rp_next;
            pend_reg      <= pend_next;
            pend_chan_reg <= pend_chan_next;
        end
    end

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// channel_chunk_reassembler testbench
// Streams chunk bytes and fetch requests into the reassembler, predicts every
// verdict and delivered message byte from a behavioral copy of the channel
// table and message store, and checks each result word field by field. Runs
// through several size limits and idle/stall mixes on both stream sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import ccr_pkg::*;

typedef logic [7:0] byte_q_t [$];

typedef struct packed {
    kind_t       kind;
    verdict_t    verdict;
    logic [7:0]  chan;
    logic [7:0]  data;
    logic        last;
    logic        done;
} resp_t;

class reassembly_scoreboard;
    int         limit;
    int         owed_bytes [CHANNELS_DEF];
    int         msg_len [CHANNELS_DEF];
    logic [7:0] store [CHANNELS_DEF * MAX_MSG_DEF];
    phase_t     phase;
    logic [7:0] cur;
    logic [63:0] hdr;
    int         cnt;
    verdict_t   err;
    int         rd_ptr;
    resp_t      expected_resps [$];
    int         errors;

    function new();
        limit = LIMIT_RESET;
        foreach (owed_bytes[c]) begin
            owed_bytes[c] = 0;
            msg_len[c] = 0;
        end
        phase = PH_CHAN;
        cur = '0;
        hdr = '0;
        cnt = 0;
        err = V_OK;
        rd_ptr = 0;
        errors = 0;
    endfunction

    function int owed_of(int ch);
        return owed_bytes[ch];
    endfunction

    function int ready_len();
        int c;
        for (c = 0; c < CHANNELS_DEF; c++) begin
            if (owed_bytes[c] == 0 && msg_len[c] != 0) return msg_len[c];
        end
        return 0;
    endfunction

    function int pending();
        return expected_resps.size();
    endfunction

    function verdict_t early_verdict();
        if (err != V_OK) return err;
        return (phase == PH_HDR) ? V_SHORT_HDR : V_NO_PAYLOAD;
    endfunction

    function resp_t close_chunk(verdict_t v, logic done);
        resp_t r;
        r = '0;
        r.kind = KIND_VERDICT;
        r.verdict = v;
        r.chan = cur;
        r.done = done;
        phase = PH_CHAN;
        cnt = 0;
        err = V_OK;
        hdr = '0;
        return r;
    endfunction

    function void note_word(logic fetch, logic [7:0] b, logic last);
        resp_t r;
        logic  emit;
        logic  found;
        int    off;
        int    c;
        r = '0;
        emit = 1'b0;
        found = 1'b0;
        if (fetch) begin
            emit = 1'b1;
            r.kind = KIND_NONE;
            for (c = 0; c < CHANNELS_DEF; c++) begin
                if (!found && owed_bytes[c] == 0 && msg_len[c] != 0) begin
                    found = 1'b1;
                    if (rd_ptr >= msg_len[c]) rd_ptr = 0;
                    r.kind = KIND_BYTE;
                    r.chan = 8'(c);
                    r.data = store[c * MAX_MSG_DEF + rd_ptr];
                    r.last = (rd_ptr + 1 == msg_len[c]);
                    if (r.last) begin
                        msg_len[c] = 0;
                        rd_ptr = 0;
                    end else begin
                        rd_ptr++;
                    end
                end
            end
        end else begin
            case (phase)
                PH_CHAN: begin
                    cur = b;
                    cnt = 0;
                    hdr = '0;
                    if (b >= CHANNELS_DEF) begin
                        err = V_BAD_CHAN;
                        phase = PH_SKIP;
                    end else if (owed_bytes[b] == 0) begin
                        phase = PH_HDR;
                    end else begin
                        phase = PH_PAY;
                    end
                    if (last) begin
                        r = close_chunk(early_verdict(), 1'b0);
                        emit = 1'b1;
                    end
                end
                PH_HDR: begin
                    hdr = {b, hdr[63:8]};
                    cnt++;
                    if (cnt >= HDR_BYTES) begin
                        if (hdr > 64'(limit) || hdr > 64'(MAX_MSG_DEF)) begin
                            err = V_OVER_LIMIT;
                            phase = PH_SKIP;
                        end else begin
                            owed_bytes[cur] = int'(hdr);
                            msg_len[cur] = int'(hdr);
                            cnt = 0;
                            phase = PH_PAY;
                            rd_ptr = 0;
                        end
                    end
                    if (last) begin
                        r = close_chunk(early_verdict(), 1'b0);
                        emit = 1'b1;
                    end
                end
                PH_PAY: begin
                    if (cnt >= owed_bytes[cur]) begin
                        err = V_TOO_LONG;
                        phase = PH_SKIP;
                    end else begin
                        off = msg_len[cur] - owed_bytes[cur] + cnt;
                        store[int'(cur) * MAX_MSG_DEF + off] = b;
                        cnt++;
                    end
                    if (last) begin
                        emit = 1'b1;
                        if (err != V_OK) begin
                            r = close_chunk(err, 1'b0);
                        end else begin
                            owed_bytes[cur] -= cnt;
                            if (owed_bytes[cur] == 0) rd_ptr = 0;
                            r = close_chunk(V_OK, owed_bytes[cur] == 0);
                        end
                    end
                end
                default: begin
                    if (last) begin
                        r = close_chunk(err, 1'b0);
                        emit = 1'b1;
                    end
                end
            endcase
        end
        if (emit) expected_resps.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act);
        if (act !== exp_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act);
            errors++;
        end
    endfunction

    function void check_result(logic [23:0] d, logic [1:0] u, logic l);
        resp_t e;
        if (expected_resps.size() == 0) begin
            $error("result word with nothing expected: tdata=%h tuser=%h", d, u);
            errors++;
            return;
        end
        e = expected_resps.pop_front();
        compare_field("resp_kind", e.kind, u);
        compare_field("verdict", e.verdict, d[2:0]);
        compare_field("chan", e.chan, d[10:3]);
        compare_field("msg_byte", e.data, d[18:11]);
        compare_field("msg_last", e.last, l);
        compare_field("message_done", e.done, d[19]);
    endfunction
endclass

module testbench;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int PHASES          = 6;
    localparam int WORDS_PER_PHASE = 110;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [SIZE_W-1:0] cfg_data = '0;

    int idle_pct = 0;
    int stall_pct = 0;
    int words_sent = 0;
    int cycle_count = 0;
    int idle_plan [PHASES] = '{0, 86, 0, 30, 0, 30};
    int stall_plan [PHASES] = '{0, 0, 86, 30, 0, 30};

    reassembly_scoreboard sb = new();

    channel_chunk_reassembler u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    task automatic send_word(input logic fetch, input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= fetch;
        s_tdata <= b;
        s_tlast <= last;
        // hold the word until it is taken
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_word(fetch, b, last);
        words_sent++;
    endtask

    task automatic send_chunk(input byte_q_t q);
        foreach (q[i]) begin
            if ($urandom_range(0, 99) < 3) send_word(1'b1, 8'($urandom), 1'($urandom));
            send_word(1'b0, q[i], i == q.size() - 1);
        end
    endtask

    function automatic void add_size(ref byte_q_t q, input logic [63:0] size);
        int k;
        for (k = 0; k < HDR_BYTES; k++) q.push_back(size[8*k +: 8]);
    endfunction

    task automatic fetch_words(input int n);
        repeat (n) send_word(1'b1, 8'($urandom), 1'($urandom));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic random_chunk();
        byte_q_t     q;
        int          ch;
        int          owed;
        int          n;
        int          pr;
        int          k;
        logic        short_hdr;
        logic [63:0] size;
        ch = ($urandom_range(0, 99) < 8) ? $urandom_range(4, 255) : $urandom_range(0, 3);
        q = {};
        q.push_back(8'(ch));
        owed = 0;
        short_hdr = 1'b0;
        if (ch < CHANNELS_DEF && sb.owed_of(ch) == 0) begin
            pr = $urandom_range(0, 99);
            if (pr < 60) size = $urandom_range(0, 24);
            else if (pr < 70) size = (sb.limit <= 64) ? sb.limit : $urandom_range(1, 24);
            else if (pr < 80) size = sb.limit + 1;
            else if (pr < 88) size = $urandom_range(MAX_MSG_DEF + 1, 8191);
            else size = {$urandom, $urandom};
            if ($urandom_range(0, 99) < 8) begin
                short_hdr = 1'b1;
                n = $urandom_range(0, HDR_BYTES - 1);
                for (k = 0; k < n; k++) q.push_back(size[8*k +: 8]);
            end else begin
                add_size(q, size);
                if (size <= sb.limit && size <= MAX_MSG_DEF) owed = int'(size);
            end
        end else if (ch < CHANNELS_DEF) begin
            owed = sb.owed_of(ch);
        end
        if (!short_hdr) begin
            pr = $urandom_range(0, 99);
            if (pr < 10) n = 0;
            else if (pr < 18) n = owed + $urandom_range(1, 2);
            else if (pr < 55 && owed > 0) n = owed;
            else n = (owed > 0) ? $urandom_range(1, owed) : $urandom_range(0, 2);
            for (k = 0; k < n; k++) q.push_back(8'($urandom));
        end
        send_chunk(q);
        if ($urandom_range(0, 99) < 35) begin
            n = sb.ready_len();
            if (n == 0) n = $urandom_range(1, 2);
            else if ($urandom_range(0, 99) < 30) n = $urandom_range(1, n);
            else n = n + $urandom_range(0, 1);
            fetch_words(n);
        end
    endtask

    initial begin
        byte_q_t q;
        int      ph;
        int      v;
        int      start;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (ph = 0; ph < PHASES; ph++) begin
            idle_pct = idle_plan[ph];
            stall_pct = stall_plan[ph];
            if (ph > 0) begin
                drain();
                case (ph)
                    1: v = 8191;
                    2: v = $urandom_range(16, 64);
                    3: v = 0;
                    4: v = $urandom_range(0, 8191);
                    default: v = 4096;
                endcase
                cfg_valid <= 1'b1;
                cfg_data <= SIZE_W'(v);
                do @(posedge aclk); while (cfg_ready !== 1'b1);
                cfg_valid <= 1'b0;
                sb.limit = v;
            end
            if (ph == 0) begin
                send_word(1'b1, 8'hFF, 1'b1);
                q = {8'hFF};
                send_chunk(q);
                q = {8'h04, 8'h00};
                send_chunk(q);
                q = {8'h00};
                send_chunk(q);
                q = {8'h01, 8'h05, 8'h00};
                send_chunk(q);
                q = {8'h02};
                add_size(q, 64'd0);
                q.push_back(8'hAA);
                send_chunk(q);
                q = {8'h00};
                add_size(q, 64'(MAX_MSG_DEF + 1));
                send_chunk(q);
                q = {8'h01};
                add_size(q, 64'd3);
                send_chunk(q);
                q = {8'h01};
                send_chunk(q);
                q = {8'h01, 8'h11, 8'h22, 8'h33, 8'h44};
                send_chunk(q);
                q = {8'h01, 8'h00, 8'hFF};
                send_chunk(q);
                fetch_words(1);
                q = {8'h01, 8'h80};
                send_chunk(q);
                fetch_words(4);
                // message in the top slot of the store, sent in two chunks
                q = {8'h03};
                add_size(q, 64'd32);
                send_chunk(q);
                repeat (2) begin
                    q = {8'h03};
                    repeat (16) q.push_back(8'($urandom));
                    send_chunk(q);
                end
                fetch_words(33);
            end
            if (ph == 1) begin
                q = {8'h00};
                add_size(q, 64'(MAX_MSG_DEF + 1));
                send_chunk(q);
            end
            start = words_sent;
            while (words_sent - start < WORDS_PER_PHASE) random_chunk();
        end
        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
